[rtl/core/grc_pkg.sv]
// shared constants, angle table and helpers for the grid ray caster
package grc_pkg;

    // fixed-point format of positions and slopes
    localparam int FRAC_BITS = 16;
    localparam int ONE_I     = 1 << FRAC_BITS;
    localparam int NUDGE     = (ONE_I + 9999) / 10000;
    localparam int SAT_SH    = 14;
    localparam int QB        = FRAC_BITS + SAT_SH;
    localparam int SLOPE_W   = QB + 1;

    // internal widths
    localparam int P_W  = 48;
    localparam int CW   = 34;
    localparam int ZW   = 26;
    localparam int TW   = FRAC_BITS + 2;

    // angle codes in turn units
    localparam int          ANG_W    = 16;
    localparam logic [15:0] ANG_ZERO = 16'd0;
    localparam logic [15:0] ANG_QTR  = 16'd16384;
    localparam logic [15:0] ANG_HALF = 16'd32768;
    localparam logic [15:0] ANG_3QTR = 16'd49152;

    // wall faces
    localparam logic [1:0] FACE_EAST  = 2'd0;
    localparam logic [1:0] FACE_WEST  = 2'd1;
    localparam logic [1:0] FACE_LOWER = 2'd2;
    localparam logic [1:0] FACE_UPPER = 2'd3;

    // rotation angles in 2^-24 turn
    localparam int CORDIC_N = 22;
    localparam logic [21:0] ATAN_TURN [CORDIC_N] = '{
        22'd2097152, 22'd1238021, 22'd654136, 22'd332050, 22'd166669, 22'd83416,
        22'd41718, 22'd20860, 22'd10430, 22'd5215, 22'd2608, 22'd1304, 22'd652,
        22'd326, 22'd163, 22'd81, 22'd41, 22'd20, 22'd10, 22'd5, 22'd3, 22'd1
    };

    // clamp a wide signed value to the signed 32-bit range
    function automatic logic [31:0] sat32(input logic signed [P_W-1:0] v);
        logic [31:0] r;
        if (v[P_W-1:31] == '0 || v[P_W-1:31] == '1) begin
            r = v[31:0];
        end else if (v[P_W-1]) begin
            r = 32'h8000_0000;
        end else begin
            r = 32'h7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

[rtl/core/grid_ray_wall_cast.sv]
// grid ray caster: map store, ray walk sequencer and shared arithmetic unit
//
//  channel    dir  handshake                      contents
//  s_axis     in   s_axis_tvalid/s_axis_tready    tuser command, tdata cell write or cast request
//  m_axis     out  m_axis_tvalid/m_axis_tready    tdata wall hit of one cast
//  cfg        in   i_cfg_we                       max_steps
//
//  after reset a clearing pass zeroes all 2^(2*MAP_SIDE_BITS) map cells (4096)
//  a cell write goes straight to the map from the idle step; a cast runs through
//  22 rotation steps, two divisions (skipped when saturated or divisor zero),
//  two walks, each set up in S_WINIT and S_WADD, four squares on the one multiplier
//  and a 32-step root
//  a finished result sits in the output register; the block takes the next request
//  while it waits and holds at the last step only if the register is still full
module grid_ray_wall_cast
    import grc_pkg::*;
#(
    parameter int MAP_SIDE_BITS  = 6,
    parameter int CELL_ATTR_BITS = 4,
    localparam int POS_W      = MAP_SIDE_BITS + FRAC_BITS,
    localparam int IN_W       = 4 * MAP_SIDE_BITS + 2 * CELL_ATTR_BITS + 2 * FRAC_BITS + ANG_W,
    localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W      = 130,
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [7:0]             i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // cell_x, cell_y, cell_attrs, start_x, start_y, ray_angle, attr_mask
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // command
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // face, tex_offset, distance, hit_x, hit_y, angle_out
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int M       = MAP_SIDE_BITS;
    localparam int A       = CELL_ATTR_BITS;
    localparam int AW      = 2 * M;
    localparam int CELLS   = 1 << AW;
    localparam int OFF_CX  = 0;
    localparam int OFF_CY  = M;
    localparam int OFF_AT  = 2 * M;
    localparam int OFF_SX  = 2 * M + A;
    localparam int OFF_SY  = OFF_SX + POS_W;
    localparam int OFF_ANG = OFF_SY + POS_W;
    localparam int OFF_MSK = OFF_ANG + ANG_W;

    // sequencer steps
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_CORDIC = 4'd2;
    localparam logic [3:0] S_QUAD   = 4'd3;
    localparam logic [3:0] S_DCHK   = 4'd4;
    localparam logic [3:0] S_DIV    = 4'd5;
    localparam logic [3:0] S_WINIT  = 4'd6;
    localparam logic [3:0] S_WADD   = 4'd7;
    localparam logic [3:0] S_WREAD  = 4'd8;
    localparam logic [3:0] S_WCHK   = 4'd9;
    localparam logic [3:0] S_SQA    = 4'd10;
    localparam logic [3:0] S_SQM    = 4'd11;
    localparam logic [3:0] S_SQS    = 4'd12;
    localparam logic [3:0] S_SEL    = 4'd13;
    localparam logic [3:0] S_SQRT   = 4'd14;
    localparam logic [3:0] S_DONE   = 4'd15;

    logic [3:0]    r_state;
    logic [7:0]    r_max_steps;
    logic [AW-1:0] r_clr_addr;
    logic [4:0]    r_iter;

    // map store
    logic [A-1:0]  r_map [CELLS];
    logic [A-1:0]  r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [A-1:0]  mem_wdata;
    logic [AW-1:0] rd_addr;

    // request fields
    logic [M-1:0]     in_cx, in_cy;
    logic [A-1:0]     in_attrs, in_mask;
    logic [POS_W-1:0] in_sx, in_sy;
    logic [ANG_W-1:0] in_ang;

    logic [POS_W-1:0] r_sx, r_sy;
    logic [ANG_W-1:0] r_ang;
    logic [A-1:0]     r_mask;

    // rotation
    logic signed [CW-1:0] r_cx, r_cy, r_cc, r_ss;
    logic signed [ZW-1:0] r_cz;
    logic signed [CW-1:0] q_cc, q_ss;
    logic                 r_has_v, r_has_h;

    // division
    logic                      r_div_sel;
    logic [31:0]               r_rem;
    logic [QB-1:0]             r_dnum, r_quo;
    logic [CW-1:0]             r_dden;
    logic signed [CW-1:0]      n_sel, d_sel;
    logic [CW-1:0]             mag_n, mag_d;
    logic [31:0]               div_rem2;
    logic [QB-1:0]             div_m;
    logic signed [SLOPE_W-1:0] div_slope;
    logic signed [SLOPE_W-1:0] r_vslope, r_hslope, cur_slope;

    // walk
    logic                  r_fam, r_wback;
    logic [7:0]            r_step;
    logic signed [P_W-1:0] r_pa, r_pc;
    logic signed [P_W-1:0] r_vx, r_vy, r_hx, r_hy;
    logic [POS_W-1:0]      w_along0, w_cross0;
    logic signed [TW-1:0]  w_tmag, walk_t;
    logic signed [P_W-1:0] w_base, w_x, w_y, sx_ext, sy_ext;
    logic                  w_back, w_in_map, w_fin;
    logic                  west, upper;

    // squares, compare and root
    logic [1:0]            r_sq_idx;
    logic [31:0]           r_opa;
    logic signed [P_W-1:0] sq_d;
    logic [P_W-1:0]        sq_abs;
    logic [64:0]           r_vsum, r_hsum, r_sum;
    logic signed [P_W-1:0] r_px, r_py;
    logic [1:0]            r_face;
    logic                  use_v;
    logic [63:0]           r_sv, r_res, r_bit;

    // shared units
    logic [64:0]         sub_a, sub_b;
    logic [65:0]         sub_d;
    logic                sub_ge;
    logic signed [32:0]  mul_a, mul_b;
    logic signed [65:0]  mul_p, r_prod;

    // output register
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [15:0]            o_tex;
    logic [31:0]            o_dist;

    assign in_cx    = s_axis_tdata[OFF_CX +: M];
    assign in_cy    = s_axis_tdata[OFF_CY +: M];
    assign in_attrs = s_axis_tdata[OFF_AT +: A];
    assign in_sx    = s_axis_tdata[OFF_SX +: POS_W];
    assign in_sy    = s_axis_tdata[OFF_SY +: POS_W];
    assign in_ang   = s_axis_tdata[OFF_ANG +: ANG_W];
    assign in_mask  = s_axis_tdata[OFF_MSK +: A];

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // map write port: clearing pass or cell write request
    assign mem_we    = (r_state == S_CLEAR)
                    || (r_state == S_IDLE && s_axis_tvalid && !s_axis_tuser);
    assign mem_waddr = (r_state == S_CLEAR) ? r_clr_addr : {in_cy, in_cx};
    assign mem_wdata = (r_state == S_CLEAR) ? '0 : in_attrs;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_map[rd_addr];
    end

    // quadrant fold of the rotated vector
    always_comb begin
        case (r_ang[15:14])
            2'd0:    begin q_cc = r_cx;  q_ss = r_cy;  end
            2'd1:    begin q_cc = -r_cy; q_ss = r_cx;  end
            2'd2:    begin q_cc = -r_cx; q_ss = -r_cy; end
            default: begin q_cc = r_cy;  q_ss = -r_cx; end
        endcase
    end

    assign west  = (r_ang > ANG_QTR) && (r_ang < ANG_3QTR);
    assign upper = (r_ang > ANG_HALF);

    // divider operands: tan first, then cot
    assign n_sel    = r_div_sel ? r_cc : r_ss;
    assign d_sel    = r_div_sel ? r_ss : r_cc;
    assign mag_n    = n_sel[CW-1] ? CW'(-n_sel) : CW'(n_sel);
    assign mag_d    = d_sel[CW-1] ? CW'(-d_sel) : CW'(d_sel);
    assign div_rem2 = {r_rem[30:0], r_dnum[QB-1]};

    always_comb begin
        if (r_state == S_DIV) begin
            div_m = {r_quo[QB-2:0], sub_ge};
        end else if (mag_d == '0) begin
            div_m = '0;
        end else begin
            div_m = '1;
        end
        div_slope = (n_sel[CW-1] ^ d_sel[CW-1]) ? -$signed({1'b0, div_m})
                                                :  $signed({1'b0, div_m});
    end

    // walk geometry
    assign cur_slope = r_fam ? r_hslope : r_vslope;
    assign w_along0  = r_fam ? r_sy : r_sx;
    assign w_cross0  = r_fam ? r_sx : r_sy;
    assign w_back    = r_fam ? upper : west;
    assign w_tmag    = $signed(TW'(w_along0[FRAC_BITS-1:0]));
    assign walk_t    = w_back ? -w_tmag : $signed(TW'(ONE_I)) - w_tmag;
    assign w_base    = $signed(P_W'({w_along0[POS_W-1:FRAC_BITS], {FRAC_BITS{1'b0}}}));
    assign sx_ext    = $signed(P_W'(r_sx));
    assign sy_ext    = $signed(P_W'(r_sy));
    assign w_x       = r_fam ? r_pc : r_pa;
    assign w_y       = r_fam ? r_pa : r_pc;
    assign w_in_map  = (w_x[P_W-1:FRAC_BITS+M] == '0) && (w_y[P_W-1:FRAC_BITS+M] == '0);
    assign rd_addr   = {w_y[FRAC_BITS +: M], w_x[FRAC_BITS +: M]};
    assign w_fin     = (r_state == S_WREAD) ? (r_step == 8'd0 || !w_in_map)
                                            : ((r_rdata & r_mask) != '0);

    // distance legs and their magnitudes, clamped to 32 bits in S_SQA
    always_comb begin
        case (r_sq_idx)
            2'd0:    sq_d = r_vx - sx_ext;
            2'd1:    sq_d = r_vy - sy_ext;
            2'd2:    sq_d = r_hx - sx_ext;
            default: sq_d = r_hy - sy_ext;
        endcase
        sq_abs = sq_d[P_W-1] ? P_W'(-sq_d) : P_W'(sq_d);
    end

    assign use_v = r_has_v && (!r_has_h || r_vsum <= r_hsum);

    // shared subtract-compare unit and multiplier
    always_comb begin
        sub_a = '0;
        sub_b = '0;
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_DCHK: begin
                sub_a = 65'(mag_n);
                sub_b = 65'({mag_d, {SAT_SH{1'b0}}});
            end
            S_DIV: begin
                sub_a = 65'(div_rem2);
                sub_b = 65'(r_dden);
            end
            S_SQRT: begin
                sub_a = {1'b0, r_sv};
                sub_b = {1'b0, r_res + r_bit};
            end
            S_WINIT: begin
                mul_a = 33'(walk_t);
                mul_b = 33'(cur_slope);
            end
            S_SQM: begin
                mul_a = $signed({1'b0, r_opa});
                mul_b = $signed({1'b0, r_opa});
            end
            default: ;
        endcase
    end

    assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge = !sub_d[65];
    assign mul_p  = mul_a * mul_b;

    // result fields
    always_comb begin
        o_tex  = (r_face == FACE_EAST || r_face == FACE_WEST) ? r_py[15:0] : r_px[15:0];
        if (r_face == FACE_WEST || r_face == FACE_LOWER) begin
            o_tex = (o_tex == 16'd0) ? 16'hFFFF : 16'd0 - o_tex;
        end
        o_dist = r_sum[64] ? 32'hFFFF_FFFF : r_res[31:0];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_max_steps <= 8'd32;
            r_out_valid <= 1'b0;
            r_iter      <= '0;
            r_div_sel   <= 1'b0;
            r_fam       <= 1'b0;
            r_step      <= '0;
            r_sq_idx    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_max_steps <= i_cfg_wdata;
            end
            // the last step reloads the register itself
            if (m_axis_tready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tuser) begin
                        r_sx    <= in_sx;
                        r_sy    <= in_sy;
                        r_ang   <= in_ang;
                        r_mask  <= in_mask;
                        r_cx    <= CW'(1 << 28);
                        r_cy    <= '0;
                        r_cz    <= $signed(ZW'({in_ang[13:0], 8'b0}));
                        r_iter  <= '0;
                        r_state <= S_CORDIC;
                    end
                end
                S_CORDIC: begin
                    if (!r_cz[ZW-1]) begin
                        r_cx <= r_cx - (r_cy >>> r_iter);
                        r_cy <= r_cy + (r_cx >>> r_iter);
                        r_cz <= r_cz - $signed(ZW'(ATAN_TURN[r_iter]));
                    end else begin
                        r_cx <= r_cx + (r_cy >>> r_iter);
                        r_cy <= r_cy - (r_cx >>> r_iter);
                        r_cz <= r_cz + $signed(ZW'(ATAN_TURN[r_iter]));
                    end
                    r_iter <= r_iter + 1'b1;
                    if (r_iter == 5'(CORDIC_N - 1)) begin
                        r_state <= S_QUAD;
                    end
                end
                S_QUAD: begin
                    r_cc      <= q_cc;
                    r_ss      <= q_ss;
                    // an axis-parallel ray never meets one line family
                    r_has_v   <= r_ang != ANG_QTR && r_ang != ANG_3QTR && q_cc != '0;
                    r_has_h   <= r_ang != ANG_ZERO && r_ang != ANG_HALF && q_ss != '0;
                    r_div_sel <= 1'b0;
                    r_state   <= S_DCHK;
                end
                S_DCHK, S_DIV: begin
                    if (r_state == S_DCHK && mag_d != '0 && !sub_ge) begin
                        r_rem   <= 32'(mag_n >> SAT_SH);
                        r_dnum  <= QB'({mag_n, {FRAC_BITS{1'b0}}});
                        r_dden  <= mag_d;
                        r_iter  <= '0;
                        r_state <= S_DIV;
                    end else if (r_state == S_DIV && r_iter != 5'(QB - 1)) begin
                        r_rem  <= sub_ge ? sub_d[31:0] : div_rem2;
                        r_dnum <= r_dnum << 1;
                        r_quo  <= div_m;
                        r_iter <= r_iter + 1'b1;
                    end else begin
                        // zero divisor, saturated or last quotient bit
                        if (r_div_sel) begin
                            r_hslope <= div_slope;
                            r_fam    <= 1'b0;
                            r_state  <= S_WINIT;
                        end else begin
                            r_vslope  <= div_slope;
                            r_div_sel <= 1'b1;
                            r_state   <= S_DCHK;
                        end
                    end
                end
                S_WINIT: begin
                    r_wback <= w_back;
                    r_pa    <= w_back ? w_base - P_W'(NUDGE) : w_base + P_W'(ONE_I);
                    r_prod  <= mul_p;
                    r_state <= S_WADD;
                end
                S_WADD: begin
                    r_pc    <= $signed(P_W'(w_cross0)) + r_prod[P_W+FRAC_BITS-1:FRAC_BITS];
                    r_step  <= r_max_steps;
                    r_state <= S_WREAD;
                end
                S_WREAD, S_WCHK: begin
                    if (w_fin) begin
                        if (r_fam) begin
                            r_hx     <= w_x;
                            r_hy     <= w_y;
                            r_sq_idx <= '0;
                            r_state  <= S_SQA;
                        end else begin
                            r_vx    <= w_x;
                            r_vy    <= w_y;
                            r_fam   <= 1'b1;
                            r_state <= S_WINIT;
                        end
                    end else if (r_state == S_WREAD) begin
                        r_step  <= r_step - 1'b1;
                        r_state <= S_WCHK;
                    end else begin
                        r_pa    <= r_wback ? r_pa - P_W'(ONE_I) : r_pa + P_W'(ONE_I);
                        r_pc    <= r_wback ? r_pc - P_W'(cur_slope) : r_pc + P_W'(cur_slope);
                        r_state <= S_WREAD;
                    end
                end
                S_SQA: begin
                    r_opa   <= (sq_abs[P_W-1:32] != '0) ? 32'hFFFF_FFFF : sq_abs[31:0];
                    r_state <= S_SQM;
                end
                S_SQM: begin
                    r_prod  <= mul_p;
                    r_state <= S_SQS;
                end
                S_SQS: begin
                    case (r_sq_idx)
                        2'd0:    r_vsum <= 65'(r_prod[63:0]);
                        2'd1:    r_vsum <= r_vsum + 65'(r_prod[63:0]);
                        2'd2:    r_hsum <= 65'(r_prod[63:0]);
                        default: r_hsum <= r_hsum + 65'(r_prod[63:0]);
                    endcase
                    r_sq_idx <= r_sq_idx + 1'b1;
                    r_state  <= (r_sq_idx == 2'd3) ? S_SEL : S_SQA;
                end
                S_SEL: begin
                    // tie goes to the vertical crossing
                    if (use_v) begin
                        r_px   <= r_vx;
                        r_py   <= r_vy;
                        r_face <= west ? FACE_WEST : FACE_EAST;
                        r_sum  <= r_vsum;
                        r_sv   <= r_vsum[63:0];
                    end else begin
                        r_px   <= r_hx;
                        r_py   <= r_hy;
                        r_face <= upper ? FACE_UPPER : FACE_LOWER;
                        r_sum  <= r_hsum;
                        r_sv   <= r_hsum[63:0];
                    end
                    r_res   <= '0;
                    r_bit   <= 64'h4000_0000_0000_0000;
                    r_iter  <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (sub_ge) begin
                        r_sv  <= sub_d[63:0];
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit  <= r_bit >> 2;
                    r_iter <= r_iter + 1'b1;
                    if (r_iter == 5'd31) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= OUT_TDATA_W'({r_ang, sat32(r_py), sat32(r_px),
                                                     o_dist, o_tex, r_face});
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // a cast keeps the input side closed for at least the next cycle
    a_cast_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> !s_axis_tready)
        else $error("input taken right after a cast");

    // a tested cell always comes out of the step budget
    a_step_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WCHK) |-> (r_step < r_max_steps))
        else $error("walk exceeded its step budget");

    // restoring divider remainder stays below the divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ({2'b00, r_rem} < r_dden))
        else $error("divider remainder out of range");

    // results appear only when a cast completes
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == S_DONE))
        else $error("result without a finished cast");
`endif

endmodule

[bench/tb_grid_ray_wall_cast.sv]
// self-checking bench for the grid ray caster: directed table, then random phases
module tb_grid_ray_wall_cast;
    import grc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  IN_TW      = 80;
    localparam int  OUT_TW     = 136;
    localparam int  SIDE_BITS  = 6;
    localparam int  MAP_CELLS  = 1 << (2 * SIDE_BITS);
    localparam int  IDLE_LIMIT = 40000;   // covers the map clearing pass and long stalls
    localparam int  PHASE_ITEMS = 320;
    localparam longint UNIT    = 64'sd1 << FRAC_BITS;
    localparam longint SLOPE_CAP = (64'sd1 << QB) - 1;

    // request kinds on tuser
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    typedef struct packed {
        logic [1:0]  face;
        logic [15:0] tex;
        logic [31:0] dst;
        logic [31:0] hx;
        logic [31:0] hy;
        logic [15:0] ang;
    } wall_hit_t;

    typedef struct {
        logic        cmd;
        logic [5:0]  cx;
        logic [5:0]  cy;
        logic [3:0]  attrs;
        logic [21:0] sx;
        logic [21:0] sy;
        logic [15:0] ang;
        logic [3:0]  mask;
        bit          face_known;   // face readable at a glance for axis-parallel rays
        logic [1:0]  face;
    } req_row_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [7:0]          i_cfg_wdata;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [IN_TW-1:0]    s_axis_tdata;   // cell_x, cell_y, cell_attrs, start_x, start_y, ray_angle, attr_mask
    logic                s_axis_tuser;   // command
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_TW-1:0]   m_axis_tdata;   // face, tex_offset, distance, hit_x, hit_y, angle_out

    grid_ray_wall_cast u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // predictor state: map shadow and step limit
    logic [3:0]  map_shadow [MAP_CELLS];
    logic [7:0]  step_limit;
    wall_hit_t   pending_hits [$];
    int          errors;
    int          idle_cycles;
    bit          calm;          // no idling in the last part of the run

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // ---------------- predictor ----------------

    function automatic void rotate_turn(input longint r, output longint c, output longint s);
        longint x, y, z, dx, dy;
        x = 64'sd1 <<< 28;
        y = 0;
        z = r <<< 8;
        for (int i = 0; i < CORDIC_N; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_TURN[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_TURN[i]);
            end
        end
        c = x;
        s = y;
    endfunction

    function automatic longint slope_of(input longint n, input longint d);
        longint m, an, ad;
        if (d == 0) return 0;
        an = (n < 0) ? -n : n;
        ad = (d < 0) ? -d : d;
        m  = (an <<< FRAC_BITS) / ad;
        if (m > SLOPE_CAP) m = SLOPE_CAP;
        return ((n < 0) != (d < 0)) ? -m : m;
    endfunction

    function automatic bit blocks_ray(input longint x, input longint y, input logic [3:0] mask);
        longint cx, cy;
        cx = x >>> FRAC_BITS;
        cy = y >>> FRAC_BITS;
        if (cx < 0 || cy < 0 || cx >= 64 || cy >= 64) return 1'b1;
        return (map_shadow[12'((cy << SIDE_BITS) | cx)] & mask) != 0;
    endfunction

    function automatic void trace_family(input longint along0, input longint cross0,
                                         input bit back, input longint slope,
                                         input bit along_x, input logic [3:0] mask,
                                         output longint hx, output longint hy);
        longint frac, pa, pc, t, step_c;
        int     n;
        frac = along0 & (UNIT - 1);
        if (!back) begin
            pa = along0 - frac + UNIT; t = UNIT - frac; step_c = slope;
        end else begin
            pa = along0 - frac - NUDGE; t = -frac; step_c = -slope;
        end
        pc = cross0 + ((t * slope) >>> FRAC_BITS);
        n  = int'(step_limit);
        while (n > 0) begin
            n--;
            if (along_x ? blocks_ray(pa, pc, mask) : blocks_ray(pc, pa, mask)) break;
            pa += back ? -UNIT : UNIT;
            pc += step_c;
        end
        hx = along_x ? pa : pc;
        hy = along_x ? pc : pa;
    endfunction

    // squared length with each leg clamped to 32 bits, 65-bit result
    function automatic logic [64:0] sq_len(input longint dx, input longint dy);
        logic [63:0] a, b;
        a = (dx < 0) ? -dx : dx;
        b = (dy < 0) ? -dy : dy;
        if (a > 64'hFFFF_FFFF) a = 64'hFFFF_FFFF;
        if (b > 64'hFFFF_FFFF) b = 64'hFFFF_FFFF;
        return {1'b0, a * a} + {1'b0, b * b};
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res, bt;
        res = 0;
        bt  = 64'd1 << 62;
        while (bt > v) bt >>= 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v -= res + bt; res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic wall_hit_t cast_ray(input logic [21:0] sx_in, input logic [21:0] sy_in,
                                           input logic [15:0] a, input logic [3:0] mask);
        longint     sx, sy, c, s, cc, ss, vx, vy, hx, hy, px, py;
        bit         has_v, has_h, west, use_v;
        logic [64:0] vd, hd;
        logic [15:0] frac;
        logic [16:0] off;
        logic [63:0] root;
        wall_hit_t  r;
        sx = longint'(sx_in);
        sy = longint'(sy_in);
        rotate_turn(longint'(a[13:0]), c, s);
        case (a[15:14])
            2'd0: begin cc = c;  ss = s;  end
            2'd1: begin cc = -s; ss = c;  end
            2'd2: begin cc = -c; ss = -s; end
            default: begin cc = s; ss = -c; end
        endcase
        has_v = a != ANG_QTR && a != ANG_3QTR && cc != 0;
        has_h = a != ANG_ZERO && a != ANG_HALF && ss != 0;
        west  = a > ANG_QTR && a < ANG_3QTR;
        trace_family(sx, sy, west, slope_of(ss, cc), 1'b1, mask, vx, vy);
        trace_family(sy, sx, a > ANG_HALF, slope_of(cc, ss), 1'b0, mask, hx, hy);
        vd = sq_len(vx - sx, vy - sy);
        hd = sq_len(hx - sx, hy - sy);
        use_v = has_v && (!has_h || vd <= hd);   // tie goes to the vertical crossing
        if (use_v) begin
            px = vx; py = vy;
            r.face = west ? FACE_WEST : FACE_EAST;
            frac = py[15:0];
        end else begin
            px = hx; py = hy;
            r.face = (a > ANG_HALF) ? FACE_UPPER : FACE_LOWER;
            frac = px[15:0];
            vd = hd;
        end
        off = {1'b0, frac};
        if (r.face == FACE_WEST || r.face == FACE_LOWER) begin
            off = 17'h10000 - off;
            if (off > 17'hFFFF) off = 17'hFFFF;
        end
        root = vd[64] ? 64'hFFFF_FFFF : int_sqrt(vd[63:0]);
        if (root > 64'hFFFF_FFFF) root = 64'hFFFF_FFFF;
        r.tex  = off[15:0];
        r.dst  = root[31:0];
        r.hx   = clamp32(px);
        r.hy   = clamp32(py);
        r.ang  = a;
        return r;
    endfunction

    // ---------------- sender ----------------

    int send_gap;

    // one request; valid stays high between back-to-back requests
    task automatic send_req(input req_row_t row);
        wall_hit_t exp_hit;
        if (!calm && send_gap == 0 && $urandom_range(0, 3) == 0)
            send_gap = $urandom_range(1, 8);
        if (send_gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (send_gap) @(posedge i_clk);
            send_gap = 0;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= row.cmd;
        s_axis_tdata  <= {row.mask, row.ang, row.sy, row.sx, row.attrs, row.cy, row.cx};
        do @(posedge i_clk); while (!s_axis_tready);
        if (row.cmd == CMD_WRITE) begin
            map_shadow[{row.cy, row.cx}] = row.attrs;
        end else begin
            exp_hit = cast_ray(row.sx, row.sy, row.ang, row.mask);
            if (row.face_known) exp_hit.face = row.face;
            pending_hits.push_back(exp_hit);
        end
    endtask

    // register writes only with the block idle
    task automatic set_steps(input logic [7:0] v);
        s_axis_tvalid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        step_limit = v;
    endtask

    function automatic req_row_t rand_req();
        req_row_t r;
        r.cmd   = ($urandom_range(0, 9) < 4) ? CMD_WRITE : CMD_CAST;
        r.cx    = 6'($urandom);
        r.cy    = 6'($urandom);
        r.attrs = 4'($urandom);
        r.sx    = 22'($urandom_range(0, 4194303));
        r.sy    = 22'($urandom_range(0, 4194303));
        // starts right on a grid line exercise the backward nudge
        if ($urandom_range(0, 7) == 0) r.sx[15:0] = 16'h0;
        if ($urandom_range(0, 7) == 0) r.sy[15:0] = 16'h0;
        r.ang = 16'($urandom);
        case ($urandom_range(0, 15))
            0: r.ang = ANG_ZERO;
            1: r.ang = ANG_QTR;
            2: r.ang = ANG_HALF;
            3: r.ang = ANG_3QTR;
            4: r.ang = 16'(ANG_QTR * $urandom_range(0, 3) + $urandom_range(0, 2) - 1);
            default: ;
        endcase
        r.mask = 4'($urandom);
        r.face_known = 1'b0;
        r.face = FACE_EAST;
        return r;
    endfunction

    function automatic req_row_t mk(input logic cmd, input logic [5:0] cx, input logic [5:0] cy,
                                    input logic [3:0] at, input logic [21:0] sx,
                                    input logic [21:0] sy, input logic [15:0] ang,
                                    input logic [3:0] mask, input bit fk, input logic [1:0] f);
        req_row_t r;
        r.cmd = cmd; r.cx = cx; r.cy = cy; r.attrs = at; r.sx = sx; r.sy = sy;
        r.ang = ang; r.mask = mask; r.face_known = fk; r.face = f;
        return r;
    endfunction

    // ---------------- receiver and checker ----------------

    int recv_gap;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_gap = 0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            recv_gap = $urandom_range(1, 8) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        wall_hit_t got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[129:0];
            got = {m_axis_tdata[1:0], m_axis_tdata[17:2], m_axis_tdata[49:18],
                   m_axis_tdata[81:50], m_axis_tdata[113:82], m_axis_tdata[129:114]};
            if (pending_hits.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_axis_tdata);
                errors++;
            end else begin
                want = pending_hits.pop_front();
                if (got.face != want.face) begin
                    $display("%0t: face exp %0d got %0d", $time, want.face, got.face); errors++;
                end
                if (got.tex != want.tex) begin
                    $display("%0t: tex_offset exp %h got %h", $time, want.tex, got.tex); errors++;
                end
                if (got.dst != want.dst) begin
                    $display("%0t: distance exp %h got %h", $time, want.dst, got.dst); errors++;
                end
                if (got.hx != want.hx) begin
                    $display("%0t: hit_x exp %h got %h", $time, want.hx, got.hx); errors++;
                end
                if (got.hy != want.hy) begin
                    $display("%0t: hit_y exp %h got %h", $time, want.hy, got.hy); errors++;
                end
                if (got.ang != want.ang) begin
                    $display("%0t: angle_out exp %h got %h", $time, want.ang, got.ang); errors++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------- stimulus ----------------

    localparam logic [21:0] MID = {6'd32, 16'h8000};

    initial begin
        req_row_t    table_rows [$];
        logic [7:0]  phase_steps [6];
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_WRITE;
        errors        = 0;
        idle_cycles   = 0;
        calm          = 1'b0;
        send_gap      = 0;
        step_limit    = 8'd32;
        foreach (map_shadow[i]) map_shadow[i] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // axis-parallel rays on the empty map, then walls, masks and edge starts
        table_rows.push_back(mk(CMD_CAST, 0, 0, 0, MID, MID, ANG_ZERO, 4'hF, 1, FACE_EAST));
        table_rows.push_back(mk(CMD_CAST, 0, 0, 0, MID, MID, ANG_QTR, 4'hF, 1, FACE_LOWER));
        table_rows.push_back(mk(CMD_CAST, 0, 0, 0, MID, MID, ANG_HALF, 4'hF, 1, FACE_WEST));
        table_rows.push_back(mk(CMD_CAST, 0, 0, 0, MID, MID, ANG_3QTR, 4'hF, 1, FACE_UPPER));
        table_rows.push_back(mk(CMD_CAST, 0, 0, 0, MID, MID, 16'hFFFF, 4'hF, 0, 0));
        table_rows.push_back(mk(CMD_CAST, 0, 0, 0, MID, MID, 16'd1, 4'hF, 0, 0));
        table_rows.push_back(mk(CMD_CAST, 0, 0, 0, MID, MID, 16'd8192, 4'hF, 0, 0));
        table_rows.push_back(mk(CMD_WRITE, 6'd33, 6'd32, 4'h1, 0, 0, 0, 0, 0, 0));
        table_rows.push_back(mk(CMD_WRITE, 6'd0, 6'd0, 4'hF, 0, 0, 0, 0, 0, 0));
        table_rows.push_back(mk(CMD_WRITE, 6'd63, 6'd63, 4'hF, 0, 0, 0, 0, 0, 0));
        table_rows.push_back(mk(CMD_CAST, 0, 0, 0, MID, MID, ANG_ZERO, 4'h1, 1, FACE_EAST));
        table_rows.push_back(mk(CMD_CAST, 0, 0, 0, MID, MID, ANG_ZERO, 4'hE, 1, FACE_EAST));
        table_rows.push_back(mk(CMD_CAST, 0, 0, 0, MID, MID, 16'd1000, 4'h0, 0, 0));
        table_rows.push_back(mk(CMD_CAST, 0, 0, 0, 22'd0, 22'd0, 16'd40000, 4'hF, 0, 0));
        table_rows.push_back(mk(CMD_CAST, 0, 0, 0, 22'h3FFFFF, 22'h3FFFFF, 16'd8192, 4'hF, 0, 0));
        table_rows.push_back(mk(CMD_CAST, 0, 0, 0, {6'd10, 16'h0}, {6'd20, 16'h0}, 16'd30000,
                                4'hF, 0, 0));
        table_rows.push_back(mk(CMD_CAST, 6'h3F, 6'h3F, 4'hF, MID, {6'd5, 16'h0}, 16'd52000,
                                4'h8, 0, 0));
        table_rows.push_back(mk(CMD_WRITE, 6'd33, 6'd32, 4'h0, 0, 0, 0, 0, 0, 0));
        table_rows.push_back(mk(CMD_CAST, 0, 0, 0, MID, MID, 16'd24576, 4'hF, 0, 0));
        foreach (table_rows[i]) send_req(table_rows[i]);

        // max_steps phases, extremes included; the last phase runs without idling
        phase_steps = '{8'd0, 8'd1, 8'd255, 8'($urandom_range(2, 254)), 8'd3, 8'd32};
        for (int p = 0; p < 6; p++) begin
            set_steps(phase_steps[p]);
            calm = (p == 5);
            for (int k = 0; k < PHASE_ITEMS; k++) send_req(rand_req());
        end
        s_axis_tvalid <= 1'b0;

        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
